// File: hw/rtl/aavr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aavr_pkg - shared types and constants for the axis-angle vector rotator
// Fixed formats: unit quantities in Q2.30, CORDIC angle table, stage latencies.
// ----------------------------------------------------------------------------
package aavr_pkg;

    localparam int UNIT_SHIFT   = 30;              // Q2.30 unit scale
    localparam int UNIT_W       = 32;              // signed unit-axis component
    localparam int CS_W         = 34;              // signed sine/cosine datapath
    localparam int ANG_W        = 32;              // binary angle
    localparam int AXM_W        = 30;              // axis magnitude after prescale
    localparam int SQ_W         = 2 * AXM_W + 2;   // sum of three squares
    localparam int ROOT_W       = SQ_W / 2;        // square-root and quotient bits
    localparam int CORDIC_STEPS = 30;

    // stage counts of each unit
    localparam int AX_LAT  = 2 * ROOT_W + 8;       // unit-axis chain
    localparam int SC_LAT  = CORDIC_STEPS + 2;     // sine/cosine chain
    localparam int ROT_LAT = 6;                    // products and saturation

    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sh0_26DD_3B6A;

    localparam logic [31:0] TURN_TABLE [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic signed [CS_W-1:0] cos_v;
        logic signed [CS_W-1:0] sin_v;
    } t_sincos;

    typedef struct packed {
        logic                     zero;
        logic signed [UNIT_W-1:0] ux;
        logic signed [UNIT_W-1:0] uy;
        logic signed [UNIT_W-1:0] uz;
    } t_unit;

    typedef struct packed {
        logic saturated;
        logic zero_axis;
    } t_flags;

endpackage

// File: hw/rtl/axis_angle_vector_rotate_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate_top - rotate a 3D vector about an arbitrary axis
// Rodrigues rotation in fixed point, streaming, one vector per clock unless m_axis stalls.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake                     Payload (lowest bits first)
// s_axis   in   s_axis_tvalid/s_axis_tready   tdata: vec_x vec_y vec_z axis_x
//                                                    axis_y axis_z turn_angle
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata: out_x out_y out_z
//                                             tuser: zero_axis saturated
//
// Takes one request per clock while the skid register is empty. The result's
// delay is set by the axis normalisation chain, a 31-stage square root
// followed by a 31-stage divider, with the CORDIC alongside.
// Synchronous active-low reset clears only valid bits; no clearing pass.
// A stall on m_axis fills one skid register, then holds the whole pipeline.
//
module axis_angle_vector_rotate_top
    import aavr_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle, zero fill
    input  logic [((6*COORD_BITS+ANG_W+7)/8)*8-1:0] s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // out_x, out_y, out_z, zero fill
    output logic [((3*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
    // zero_axis, saturated
    output logic [1:0]                             m_axis_tuser
);

    localparam int CB       = COORD_BITS;
    localparam int OUT_W    = ((3 * CB + 7) / 8) * 8;
    localparam int PIPE_LAT = AX_LAT + ROT_LAT;
    localparam int USER_ZERO = 0;
    localparam int USER_SAT  = 1;

    logic                ce;
    logic [2:0][CB-1:0]  in_vec, in_axis;
    logic [ANG_W-1:0]    in_angle;

    t_unit               unit;
    t_sincos             sc_raw, sc_al;
    logic [2:0][CB-1:0]  vec_al;
    logic [2:0][CB-1:0]  rot_res;
    t_flags              rot_flags;

    logic [PIPE_LAT-1:0] r_vld;
    logic                pipe_vld;
    logic                out_take;

    logic                r_out_vld, r_skid_vld;
    logic [2:0][CB-1:0]  r_out_data, r_skid_data;
    t_flags              r_out_user, r_skid_user;

    // advance the whole pipeline unless the skid register is occupied
    assign ce            = ~r_skid_vld;
    assign s_axis_tready = ce;

    // unpack the request
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_vec[i]  = s_axis_tdata[i*CB +: CB];
            in_axis[i] = s_axis_tdata[(3+i)*CB +: CB];
        end
    end
    assign in_angle = s_axis_tdata[6*CB +: ANG_W];

    // unit axis: the longest path through the design
    aavr_unit_axis #(
        .COORD_BITS (CB)
    ) u_unit_axis (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_axis (in_axis),
        .o_unit (unit)
    );

    // sine and cosine, then delayed to meet the unit axis
    aavr_sincos u_sincos (
        .i_clk   (i_clk),
        .i_ce    (ce),
        .i_angle (in_angle),
        .o_sc    (sc_raw)
    );

    aavr_delay #(
        .W     ($bits(t_sincos)),
        .DEPTH (AX_LAT - SC_LAT)
    ) u_sc_delay (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_d   (sc_raw),
        .o_q   (sc_al)
    );

    // hold the vector until its unit axis is ready
    aavr_delay #(
        .W     (3 * CB),
        .DEPTH (AX_LAT)
    ) u_vec_delay (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_d   (in_vec),
        .o_q   (vec_al)
    );

    aavr_rotate #(
        .COORD_BITS (CB)
    ) u_rotate (
        .i_clk   (i_clk),
        .i_ce    (ce),
        .i_vec   (vec_al),
        .i_unit  (unit),
        .i_sc    (sc_al),
        .o_res   (rot_res),
        .o_flags (rot_flags)
    );

    // valid bits travel alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], s_axis_tvalid};
        end
    end

    assign pipe_vld = r_vld[PIPE_LAT-1];
    assign out_take = r_out_vld & m_axis_tready;

    // output register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (out_take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (pipe_vld) begin
            if (r_out_vld && !out_take) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (out_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (out_take) begin
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
            end
        end else if (pipe_vld) begin
            if (r_out_vld && !out_take) begin
                r_skid_data <= rot_res;
                r_skid_user <= rot_flags;
            end else begin
                r_out_data <= rot_res;
                r_out_user <= rot_flags;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_W'(r_out_data);
    assign m_axis_tuser  = r_out_user;

    // skid only ever holds a request behind a full output register
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry held with empty output register");

    // skid fills only from a valid pipeline end
    a_skid_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(pipe_vld))
        else $error("skid filled without a valid request");

    // a null axis never reports clipping
    a_flags_excl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[USER_ZERO] && m_axis_tuser[USER_SAT]))
        else $error("zero_axis and saturated both set");

    // a null axis yields a zero vector
    a_zero_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[USER_ZERO]) |-> (m_axis_tdata == '0))
        else $error("zero axis with non-zero result");

endmodule

// File: hw/rtl/aavr_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aavr_delay - stall-aware alignment delay line
// Moves a word through DEPTH registers, advancing only on clock enable.
// ----------------------------------------------------------------------------
module aavr_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_ce,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule

// File: hw/rtl/aavr_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aavr_sincos - pipelined CORDIC sine and cosine
// Quadrant fold, one rotation step per stage, then quadrant restore.
// ----------------------------------------------------------------------------
module aavr_sincos
    import aavr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_ce,
    input  logic [ANG_W-1:0] i_angle,
    output t_sincos          o_sc
);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    logic [ANG_W-1:0] ang_bias;
    logic [1:0]       pre_q;
    logic [ANG_W-1:0] pre_rd;

    logic signed [CS_W-1:0] r_pre_z;
    logic [1:0]             r_pre_q;

    logic signed [CS_W-1:0] r_cx [1:CORDIC_STEPS];
    logic signed [CS_W-1:0] r_cy [1:CORDIC_STEPS];
    logic signed [CS_W-1:0] r_cz [1:CORDIC_STEPS];
    logic [1:0]             r_cq [1:CORDIC_STEPS];

    t_sincos n_sc;
    t_sincos r_sc;

    // fold the angle to within an eighth of a turn of zero
    assign ang_bias = i_angle + ANG_W'(32'h2000_0000);
    assign pre_q    = ang_bias[ANG_W-1 -: 2];
    assign pre_rd   = i_angle - {pre_q, {(ANG_W-2){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_pre_z <= CS_W'($signed(pre_rd));
            r_pre_q <= pre_q;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        logic signed [CS_W-1:0] src_x, src_y, src_z;
        logic [1:0]             src_q;
        logic signed [CS_W-1:0] dx, dy, ang;
        if (k == 0) begin : g_first
            assign src_x = CORDIC_GAIN;
            assign src_y = '0;
            assign src_z = r_pre_z;
            assign src_q = r_pre_q;
        end else begin : g_next
            assign src_x = r_cx[k];
            assign src_y = r_cy[k];
            assign src_z = r_cz[k];
            assign src_q = r_cq[k];
        end
        assign dx  = src_y >>> k;
        assign dy  = src_x >>> k;
        assign ang = $signed({{(CS_W-32){1'b0}}, TURN_TABLE[k]});
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                if (!src_z[CS_W-1]) begin
                    r_cx[k+1] <= src_x - dx;
                    r_cy[k+1] <= src_y + dy;
                    r_cz[k+1] <= src_z - ang;
                end else begin
                    r_cx[k+1] <= src_x + dx;
                    r_cy[k+1] <= src_y - dy;
                    r_cz[k+1] <= src_z + ang;
                end
                r_cq[k+1] <= src_q;
            end
        end
    end

    // restore the quadrant
    always_comb begin
        unique case (r_cq[CORDIC_STEPS])
            QUAD_0: begin
                n_sc.cos_v = r_cx[CORDIC_STEPS];
                n_sc.sin_v = r_cy[CORDIC_STEPS];
            end
            QUAD_1: begin
                n_sc.cos_v = -r_cy[CORDIC_STEPS];
                n_sc.sin_v = r_cx[CORDIC_STEPS];
            end
            QUAD_2: begin
                n_sc.cos_v = -r_cx[CORDIC_STEPS];
                n_sc.sin_v = -r_cy[CORDIC_STEPS];
            end
            QUAD_3: begin
                n_sc.cos_v = r_cy[CORDIC_STEPS];
                n_sc.sin_v = -r_cx[CORDIC_STEPS];
            end
            default: begin
                n_sc = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_sc <= n_sc;
        end
    end

    assign o_sc = r_sc;

endmodule

// File: hw/rtl/aavr_unit_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aavr_unit_axis - pipelined axis normalisation to Q2.30
// Prescale, sum of squares, bit-per-stage square root, bit-per-stage divide.
// ----------------------------------------------------------------------------
module aavr_unit_axis
    import aavr_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_ce,
    input  logic [2:0][COORD_BITS-1:0] i_axis,
    output t_unit                      o_unit
);

    localparam int SH_W  = $clog2(COORD_BITS + 1);
    localparam int SR_W  = ROOT_W + 5;                 // root remainder
    localparam int NUM_W = AXM_W + UNIT_SHIFT + 1;     // dividend
    localparam int REM_W = ROOT_W + 1;                 // divide remainder

    typedef struct packed {
        logic                  zero;
        logic [2:0]            neg;
        logic [2:0][AXM_W-1:0] am;
    } t_sq_side;

    typedef struct packed {
        logic       zero;
        logic [2:0] neg;
    } t_dv_side;

    // prescale stages
    logic [2:0][COORD_BITS-1:0] n_u1_mag;
    logic [2:0][COORD_BITS-1:0] r_u1_mag, r_u2_mag, r_u3_mag;
    logic [2:0]                 r_u1_neg, r_u2_neg, r_u3_neg;
    logic [COORD_BITS-1:0]      n_u2_max, m01;
    logic [COORD_BITS-1:0]      r_u2_max;
    logic [SH_W-1:0]            n_u3_sh;
    logic [SH_W-1:0]            r_u3_sh;
    logic                       r_u3_zero;
    t_sq_side                   n_u4_side;
    t_sq_side                   r_u4_side, r_u5_side, r_u6_side;
    logic [2:0][2*AXM_W-1:0]    r_u5_sq;
    logic [SQ_W-1:0]            r_u6_sum;

    // square root stages
    logic [SQ_W-1:0]   r_sq_rad  [1:ROOT_W];
    logic [SR_W-1:0]   r_sq_rem  [1:ROOT_W];
    logic [ROOT_W-1:0] r_sq_root [1:ROOT_W];
    t_sq_side          r_sq_side [1:ROOT_W];

    // divide set-up and stages
    logic [2:0][NUM_W-1:0]  d0_num;
    logic [2:0][REM_W-1:0]  r_d0_rem;
    logic [2:0][ROOT_W-1:0] r_d0_bits;
    logic [ROOT_W-1:0]      r_d0_den;
    t_dv_side               r_d0_side;

    logic [2:0][REM_W-1:0]  r_dv_rem  [1:ROOT_W];
    logic [2:0][ROOT_W-1:0] r_dv_bits [1:ROOT_W];
    logic [2:0][ROOT_W-1:0] r_dv_quo  [1:ROOT_W];
    logic [ROOT_W-1:0]      r_dv_den  [1:ROOT_W];
    t_dv_side               r_dv_side [1:ROOT_W];

    t_unit n_unit;
    t_unit r_unit;

    // magnitudes and signs
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_u1_mag[i] = i_axis[i][COORD_BITS-1] ? (~i_axis[i]) + COORD_BITS'(1)
                                                  : i_axis[i];
        end
    end

    assign m01      = (r_u1_mag[0] > r_u1_mag[1]) ? r_u1_mag[0] : r_u1_mag[1];
    assign n_u2_max = (m01 > r_u1_mag[2]) ? m01 : r_u1_mag[2];

    // shift that keeps AXM_W bits of magnitude
    always_comb begin
        n_u3_sh = '0;
        for (int b = AXM_W; b < COORD_BITS; b++) begin
            if (r_u2_max[b]) begin
                n_u3_sh = SH_W'(b + 1 - AXM_W);
            end
        end
    end

    always_comb begin
        n_u4_side.zero = r_u3_zero;
        n_u4_side.neg  = r_u3_neg;
        for (int i = 0; i < 3; i++) begin
            n_u4_side.am[i] = AXM_W'(r_u3_mag[i] >> r_u3_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_u1_mag  <= n_u1_mag;
            r_u1_neg  <= {i_axis[2][COORD_BITS-1], i_axis[1][COORD_BITS-1],
                          i_axis[0][COORD_BITS-1]};
            r_u2_mag  <= r_u1_mag;
            r_u2_neg  <= r_u1_neg;
            r_u2_max  <= n_u2_max;
            r_u3_mag  <= r_u2_mag;
            r_u3_neg  <= r_u2_neg;
            r_u3_sh   <= n_u3_sh;
            r_u3_zero <= (r_u2_max == '0);
            r_u4_side <= n_u4_side;
            for (int i = 0; i < 3; i++) begin
                r_u5_sq[i] <= r_u4_side.am[i] * r_u4_side.am[i];
            end
            r_u5_side <= r_u4_side;
            r_u6_sum  <= SQ_W'(r_u5_sq[0]) + SQ_W'(r_u5_sq[1]) + SQ_W'(r_u5_sq[2]);
            r_u6_side <= r_u5_side;
        end
    end

    // restoring square root, one root bit per stage
    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        logic [SQ_W-1:0]   src_rad;
        logic [SR_W-1:0]   src_rem;
        logic [ROOT_W-1:0] src_root;
        t_sq_side          src_side;
        logic [SR_W-1:0]   trial, test;
        logic              take;
        if (k == 0) begin : g_first
            assign src_rad  = r_u6_sum;
            assign src_rem  = '0;
            assign src_root = '0;
            assign src_side = r_u6_side;
        end else begin : g_next
            assign src_rad  = r_sq_rad[k];
            assign src_rem  = r_sq_rem[k];
            assign src_root = r_sq_root[k];
            assign src_side = r_sq_side[k];
        end
        assign trial = {src_rem[SR_W-3:0], src_rad[SQ_W-1 -: 2]};
        assign test  = SR_W'({src_root, 2'b01});
        assign take  = (trial >= test);
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_sq_rad[k+1]  <= src_rad << 2;
                r_sq_rem[k+1]  <= take ? trial - test : trial;
                r_sq_root[k+1] <= {src_root[ROOT_W-2:0], take};
                r_sq_side[k+1] <= src_side;
            end
        end
    end

    // dividend with half the divisor added for rounding
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d0_num[i] = NUM_W'({r_sq_side[ROOT_W].am[i], {UNIT_SHIFT{1'b0}}})
                      + NUM_W'(r_sq_root[ROOT_W] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < 3; i++) begin
                r_d0_rem[i]  <= REM_W'(d0_num[i] >> ROOT_W);
                r_d0_bits[i] <= d0_num[i][ROOT_W-1:0];
            end
            r_d0_den       <= r_sq_root[ROOT_W];
            r_d0_side.zero <= r_sq_side[ROOT_W].zero;
            r_d0_side.neg  <= r_sq_side[ROOT_W].neg;
        end
    end

    // restoring divide, one quotient bit per stage, three lanes
    for (genvar k = 0; k < ROOT_W; k++) begin : g_div
        logic [2:0][REM_W-1:0]  src_rem;
        logic [2:0][ROOT_W-1:0] src_bits;
        logic [2:0][ROOT_W-1:0] src_quo;
        logic [ROOT_W-1:0]      src_den;
        t_dv_side               src_side;
        logic [2:0][REM_W-1:0]  trial, nxt_rem;
        logic [2:0]             take;
        if (k == 0) begin : g_first
            assign src_rem  = r_d0_rem;
            assign src_bits = r_d0_bits;
            assign src_quo  = '0;
            assign src_den  = r_d0_den;
            assign src_side = r_d0_side;
        end else begin : g_next
            assign src_rem  = r_dv_rem[k];
            assign src_bits = r_dv_bits[k];
            assign src_quo  = r_dv_quo[k];
            assign src_den  = r_dv_den[k];
            assign src_side = r_dv_side[k];
        end
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                trial[i]   = {src_rem[i][REM_W-2:0], src_bits[i][ROOT_W-1]};
                take[i]    = (trial[i] >= REM_W'(src_den));
                nxt_rem[i] = take[i] ? trial[i] - REM_W'(src_den) : trial[i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                for (int i = 0; i < 3; i++) begin
                    r_dv_rem[k+1][i]  <= nxt_rem[i];
                    r_dv_bits[k+1][i] <= src_bits[i] << 1;
                    r_dv_quo[k+1][i]  <= {src_quo[i][ROOT_W-2:0], take[i]};
                end
                r_dv_den[k+1]  <= src_den;
                r_dv_side[k+1] <= src_side;
            end
        end
    end

    // reapply signs
    always_comb begin
        n_unit.zero = r_dv_side[ROOT_W].zero;
        n_unit.ux   = r_dv_side[ROOT_W].neg[0] ? -UNIT_W'(r_dv_quo[ROOT_W][0])
                                               : UNIT_W'(r_dv_quo[ROOT_W][0]);
        n_unit.uy   = r_dv_side[ROOT_W].neg[1] ? -UNIT_W'(r_dv_quo[ROOT_W][1])
                                               : UNIT_W'(r_dv_quo[ROOT_W][1]);
        n_unit.uz   = r_dv_side[ROOT_W].neg[2] ? -UNIT_W'(r_dv_quo[ROOT_W][2])
                                               : UNIT_W'(r_dv_quo[ROOT_W][2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_unit <= n_unit;
        end
    end

    assign o_unit = r_unit;

endmodule

// File: hw/rtl/aavr_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aavr_rotate - Rodrigues product pipeline with saturation
// v*c + (u x v)*s + u*(u.v)*(1 - c), every product rounded to Q2.30.
// ----------------------------------------------------------------------------
module aavr_rotate
    import aavr_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_ce,
    input  logic [2:0][COORD_BITS-1:0] i_vec,
    input  t_unit                      i_unit,
    input  t_sincos                    i_sc,
    output logic [2:0][COORD_BITS-1:0] o_res,
    output t_flags                     o_flags
);

    localparam int CB    = COORD_BITS;
    localparam int MW    = CB + 2;            // single rounded product
    localparam int DW    = CB + 4;            // dot and cross terms
    localparam int TW    = CB + 6;            // axial term
    localparam int SW    = CB + 8;            // final sum
    localparam int OMC_W = CS_W + 1;
    localparam int PVU_W = CB + UNIT_W;
    localparam int PVC_W = CB + CS_W;
    localparam int PT_W  = DW + OMC_W;
    localparam int PCS_W = DW + CS_W;
    localparam int PTU_W = TW + UNIT_W;

    localparam logic signed [PVU_W-1:0] RND_VU = PVU_W'(2 ** (UNIT_SHIFT - 1));
    localparam logic signed [PVC_W-1:0] RND_VC = PVC_W'(2 ** (UNIT_SHIFT - 1));
    localparam logic signed [PT_W-1:0]  RND_T  = PT_W'(2 ** (UNIT_SHIFT - 1));
    localparam logic signed [PCS_W-1:0] RND_CS = PCS_W'(2 ** (UNIT_SHIFT - 1));
    localparam logic signed [PTU_W-1:0] RND_TU = PTU_W'(2 ** (UNIT_SHIFT - 1));

    logic signed [CB-1:0]     vec_s [3];
    logic signed [UNIT_W-1:0] u_s   [3];

    // stage 1
    logic signed [PVU_W-1:0]  p_vu  [3][3];
    logic signed [PVC_W-1:0]  p_vc  [3];
    logic signed [MW-1:0]     r1_vu [3][3];
    logic signed [MW-1:0]     r1_vc [3];
    logic signed [OMC_W-1:0]  r1_omc;
    logic signed [CS_W-1:0]   r1_s;
    logic signed [UNIT_W-1:0] r1_u  [3];
    logic                     r1_zero;

    // stage 2
    logic signed [DW-1:0]     r2_d;
    logic signed [DW-1:0]     r2_cr [3];
    logic signed [MW-1:0]     r2_vc [3];
    logic signed [OMC_W-1:0]  r2_omc;
    logic signed [CS_W-1:0]   r2_s;
    logic signed [UNIT_W-1:0] r2_u  [3];
    logic                     r2_zero;

    // stage 3
    logic signed [PT_W-1:0]   p_t;
    logic signed [PCS_W-1:0]  p_cs  [3];
    logic signed [TW-1:0]     r3_t;
    logic signed [DW-1:0]     r3_cs [3];
    logic signed [MW-1:0]     r3_vc [3];
    logic signed [UNIT_W-1:0] r3_u  [3];
    logic                     r3_zero;

    // stage 4
    logic signed [PTU_W-1:0]  p_tu  [3];
    logic signed [TW-1:0]     r4_tu [3];
    logic signed [DW-1:0]     r4_cs [3];
    logic signed [MW-1:0]     r4_vc [3];
    logic                     r4_zero;

    // stage 5 and 6
    logic signed [SW-1:0]       r5_sum [3];
    logic                       r5_zero;
    logic [2:0][CB-1:0]         n_res;
    logic [2:0]                 clip;
    logic [2:0][CB-1:0]         r6_res;
    t_flags                     r6_flags;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            vec_s[i] = $signed(i_vec[i]);
        end
        u_s[0] = i_unit.ux;
        u_s[1] = i_unit.uy;
        u_s[2] = i_unit.uz;
    end

    // all vector-by-axis and vector-by-cosine products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                p_vu[i][j] = vec_s[i] * u_s[j];
            end
            p_vc[i] = vec_s[i] * i_sc.cos_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r1_vu[i][j] <= MW'((p_vu[i][j] + RND_VU) >>> UNIT_SHIFT);
                end
                r1_vc[i] <= MW'((p_vc[i] + RND_VC) >>> UNIT_SHIFT);
                r1_u[i]  <= u_s[i];
            end
            r1_omc  <= OMC_W'(2 ** UNIT_SHIFT) - OMC_W'(i_sc.cos_v);
            r1_s    <= i_sc.sin_v;
            r1_zero <= i_unit.zero;
        end
    end

    // dot and cross
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r2_d     <= DW'(r1_vu[0][0]) + DW'(r1_vu[1][1]) + DW'(r1_vu[2][2]);
            r2_cr[0] <= DW'(r1_vu[2][1]) - DW'(r1_vu[1][2]);
            r2_cr[1] <= DW'(r1_vu[0][2]) - DW'(r1_vu[2][0]);
            r2_cr[2] <= DW'(r1_vu[1][0]) - DW'(r1_vu[0][1]);
            r2_vc    <= r1_vc;
            r2_u     <= r1_u;
            r2_omc   <= r1_omc;
            r2_s     <= r1_s;
            r2_zero  <= r1_zero;
        end
    end

    always_comb begin
        p_t = r2_d * r2_omc;
        for (int i = 0; i < 3; i++) begin
            p_cs[i] = r2_cr[i] * r2_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r3_t <= TW'((p_t + RND_T) >>> UNIT_SHIFT);
            for (int i = 0; i < 3; i++) begin
                r3_cs[i] <= DW'((p_cs[i] + RND_CS) >>> UNIT_SHIFT);
            end
            r3_vc   <= r2_vc;
            r3_u    <= r2_u;
            r3_zero <= r2_zero;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p_tu[i] = r3_t * r3_u[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < 3; i++) begin
                r4_tu[i] <= TW'((p_tu[i] + RND_TU) >>> UNIT_SHIFT);
            end
            r4_cs   <= r3_cs;
            r4_vc   <= r3_vc;
            r4_zero <= r3_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < 3; i++) begin
                r5_sum[i] <= SW'(r4_vc[i]) + SW'(r4_cs[i]) + SW'(r4_tu[i]);
            end
            r5_zero <= r4_zero;
        end
    end

    // clip to the coordinate range, force zero for a null axis
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            clip[i] = !((&r5_sum[i][SW-1:CB-1]) || (~|r5_sum[i][SW-1:CB-1]));
            if (r5_zero) begin
                n_res[i] = '0;
            end else if (clip[i]) begin
                n_res[i] = {r5_sum[i][SW-1], {(CB-1){~r5_sum[i][SW-1]}}};
            end else begin
                n_res[i] = r5_sum[i][CB-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r6_res             <= n_res;
            r6_flags.zero_axis <= r5_zero;
            r6_flags.saturated <= !r5_zero && (|clip);
        end
    end

    assign o_res   = r6_res;
    assign o_flags = r6_flags;

endmodule
